/* rtl/fsmk_pkg.sv */
// Shared types, sizes and helpers for the flow shop makespan core.
`default_nettype none

package fsmk_pkg;

  localparam int JOB_COUNT     = 1024;
  localparam int MACHINE_COUNT = 16;
  localparam int TIME_BITS     = 16;

  // Fixed field widths of the transactions.
  localparam int CFG_W   = 5;
  localparam int JOB_W   = 10;
  localparam int MACH_W  = 4;
  localparam int PTIME_W = 16;
  localparam int COMP_W  = 32;

  localparam int JOB_AW    = (JOB_COUNT > 1) ? $clog2(JOB_COUNT) : 1;
  localparam int JOB_IDX_W = (JOB_AW < JOB_W) ? JOB_AW : JOB_W;
  localparam int MACH_AW   = (MACHINE_COUNT > 1) ? $clog2(MACHINE_COUNT) : 1;
  localparam int CNT_W     = $clog2(MACHINE_COUNT + 1);

  localparam logic [CFG_W-1:0] MACHINES_RESET = CFG_W'(16);

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [JOB_W-1:0]   job;
    logic [MACH_W-1:0]  machine;
    logic [PTIME_W-1:0] proc_time;
    logic               first_job;
    logic               last_job;
  } in_t;

  typedef struct packed {
    logic [COMP_W-1:0] completion;
    logic              is_makespan;
    logic              overflow;
  } out_t;

  // Transaction as it travels down the chain of machine cells.
  typedef struct packed {
    logic              valid;
    in_t               item;
    logic [COMP_W-1:0] left;
    logic              ovf;
  } tok_t;

  // Map the raw register value to the number of cells that compute.
  function automatic logic [CNT_W-1:0] clamp_machines(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] n;
    if (v == '0) begin
      n = CNT_W'(1);
    end else if (int'(v) > MACHINE_COUNT) begin
      n = CNT_W'(MACHINE_COUNT);
    end else begin
      n = CNT_W'(v);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/fsmk_cell.sv */
// One machine cell: time column, completion entry and sticky overflow.
`default_nettype none

module fsmk_cell (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire  [fsmk_pkg::MACH_AW-1:0] index,
  input  wire  [fsmk_pkg::CNT_W-1:0]   n_active,
  input  fsmk_pkg::tok_t               tok_in,
  output fsmk_pkg::tok_t               tok_out
);
  import fsmk_pkg::*;

  logic [TIME_BITS-1:0] time_mem [JOB_COUNT];

  tok_t                 st;
  logic                 st_job_ok;
  logic [TIME_BITS-1:0] rdata;
  logic [COMP_W-1:0]    row;
  logic                 sticky;

  logic                 in_job_ok;
  logic                 active;
  logic [COMP_W-1:0]    above;
  logic [COMP_W-1:0]    start;
  logic [TIME_BITS-1:0] t;
  logic [COMP_W:0]      sum;
  logic                 sat;
  logic [COMP_W-1:0]    c;
  logic                 sticky_eff;
  logic                 is_eval;

  assign in_job_ok = (32'(tok_in.item.job) < JOB_COUNT);
  assign active    = (32'(index) < 32'(n_active));
  assign is_eval   = st.valid && (st.item.kind == KIND_EVAL);

  // Completion of this job on this machine.
  always_comb begin
    above      = st.item.first_job ? '0 : row;
    start      = (st.left > above) ? st.left : above;
    t          = st_job_ok ? rdata : '0;
    sum        = (COMP_W+1)'(start) + (COMP_W+1)'(t);
    sat        = sum[COMP_W];
    c          = sat ? '1 : sum[COMP_W-1:0];
    sticky_eff = st.item.first_job ? 1'b0 : sticky;
  end

  // Time column: write on a load for this machine, read on an evaluate.
  always_ff @(posedge clk) begin
    if (en && tok_in.valid && in_job_ok) begin
      if (tok_in.item.kind == KIND_LOAD) begin
        if (32'(tok_in.item.machine) == 32'(index)) begin
          time_mem[tok_in.item.job[JOB_IDX_W-1:0]] <= TIME_BITS'(tok_in.item.proc_time);
        end
      end else begin
        rdata <= time_mem[tok_in.item.job[JOB_IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid      <= 1'b0;
      tok_out.valid <= 1'b0;
      row           <= '0;
      sticky        <= 1'b0;
    end else if (en) begin
      st.valid      <= tok_in.valid;
      tok_out.valid <= st.valid;
      if (is_eval) begin
        if (active) begin
          row    <= c;
          sticky <= sticky_eff | sat;
        end else if (st.item.first_job) begin
          row    <= '0;
          sticky <= 1'b0;
        end
      end
    end
    // Payload of both stages.
    if (en) begin
      st.item      <= tok_in.item;
      st.left      <= tok_in.left;
      st.ovf       <= tok_in.ovf;
      st_job_ok    <= in_job_ok;
      tok_out.item <= st.item;
      if (is_eval && active) begin
        tok_out.left <= c;
        tok_out.ovf  <= st.ovf | sticky_eff | sat;
      end else begin
        tok_out.left <= st.left;
        tok_out.ovf  <= st.ovf | (is_eval ? sticky_eff : 1'b0);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/fsmk_skid.sv */
// Output register with one skid entry between the chain and the result channel.
`default_nettype none

module fsmk_skid (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  input  fsmk_pkg::out_t in_data,
  output logic           in_ready,
  output logic           out_valid,
  input  wire            out_stall,
  output fsmk_pkg::out_t out_data
);
  import fsmk_pkg::*;

  logic skid_valid;
  out_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/flow_shop_makespan_core.sv */
// Top level of the permutation flow shop makespan core.
//
// Input channel (in_valid / in_stall / in_data): each transaction either loads
// one processing time (kind = load, at job and machine) or evaluates the next
// job of a sequence (kind = evaluate). Loads produce no result; every evaluate
// produces one result on the output channel (out_valid / out_stall / out_data)
// with the job's completion on the last machine in use, the makespan mark
// (copy of last_job) and the sticky saturation flag of the sequence.
// cfg_wr_en / cfg_wr_data write machines_used; write it only while idle.
//
// Transactions walk a chain of one cell per machine, each cell with a time
// memory read stage, then a max-plus-add stage; an evaluate then passes
// through the output register. A new transaction is accepted every cycle;
// the chain only halts when the output register and its skid entry are both
// full, which raises in_stall until the receiver drains. Reset clears all
// completions, the overflow flag and every valid bit and sets machines_used
// to 16; the time tables hold garbage until loaded.
`default_nettype none

module flow_shop_makespan_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_wr_en,
  input  wire  [fsmk_pkg::CFG_W-1:0]   cfg_wr_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  fsmk_pkg::in_t                in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output fsmk_pkg::out_t               out_data
);
  import fsmk_pkg::*;

  logic [CNT_W-1:0] n_active;
  tok_t             chain [MACHINE_COUNT+1];
  logic             chain_en;
  logic             res_valid;
  out_t             res_data;
  logic             skid_ready;

  // Hold the clamped machine count; only its effect matters.
  always_ff @(posedge clk) begin
    if (rst) begin
      n_active <= clamp_machines(MACHINES_RESET);
    end else if (cfg_wr_en) begin
      n_active <= clamp_machines(cfg_wr_data);
    end
  end

  // Advance the whole chain whenever the skid entry is free.
  assign chain_en = skid_ready;
  assign in_stall = !skid_ready;

  // Feed the head of the chain; the first machine sees no left neighbor.
  assign chain[0] = '{valid: in_valid, item: in_data, left: '0, ovf: 1'b0};

  for (genvar m = 0; m < MACHINE_COUNT; m++) begin : g_cell
    fsmk_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (chain_en),
      .index    (MACH_AW'(m)),
      .n_active (n_active),
      .tok_in   (chain[m]),
      .tok_out  (chain[m+1])
    );
  end

  // Drop loads at the tail; evaluates carry the last active completion.
  assign res_valid = chain_en && chain[MACHINE_COUNT].valid &&
                     (chain[MACHINE_COUNT].item.kind == KIND_EVAL);

  always_comb begin
    res_data.completion  = chain[MACHINE_COUNT].left;
    res_data.is_makespan = chain[MACHINE_COUNT].item.last_job;
    res_data.overflow    = chain[MACHINE_COUNT].ovf;
  end

  fsmk_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res_data),
    .in_ready  (skid_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A halted chain means a result is parked at the output.
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Once the receiver takes a result, the skid entry drains and input reopens.
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (in_stall && !out_stall) |=> (out_valid && !in_stall))
    else $error("skid entry did not drain");

  // The clamped machine count stays within the chain.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (n_active != '0) && (32'(n_active) <= MACHINE_COUNT))
    else $error("machine count out of range");

endmodule

`default_nettype wire
